>>> sv/vbfe_pkg.sv
// ----------------------------------------------------------------------------
// vbfe_pkg: shared types and constants for the voxel boundary face extractor
// Command format between the front and back ends, direction codes and a
// small priority helper used when emitting face records.
// ----------------------------------------------------------------------------
package vbfe_pkg;

	// default grid edge length in voxels
	localparam int GRID_SIZE_DEF = 64;

	// field widths
	localparam int COORD_W   = 6;
	localparam int DIR_W     = 3;
	localparam int NUM_DIR   = 6;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	// command queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// item kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// face normals, also the bit positions in neighbour masks
	localparam logic [DIR_W-1:0] DIR_ZN = 3'd0;
	localparam logic [DIR_W-1:0] DIR_ZP = 3'd1;
	localparam logic [DIR_W-1:0] DIR_XN = 3'd2;
	localparam logic [DIR_W-1:0] DIR_XP = 3'd3;
	localparam logic [DIR_W-1:0] DIR_YN = 3'd4;
	localparam logic [DIR_W-1:0] DIR_YP = 3'd5;

	// classified command, only interior voxels get this far
	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               occ;
		logic [NUM_DIR-1:0] nb_in;  // neighbour lies inside the shell
	} cmd_t;

	// queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// lowest set direction in a mask
	function automatic logic [DIR_W-1:0] first_dir(input logic [NUM_DIR-1:0] m);
		logic [DIR_W-1:0] d;
		d = DIR_ZN;
		for (int i = NUM_DIR - 1; i >= 0; i--) begin
			if (m[i]) begin
				d = DIR_W'(i);
			end
		end
		return d;
	endfunction

endpackage

>>> sv/vbfe_front.sv
// ----------------------------------------------------------------------------
// vbfe_front: input item acceptance and classification
// Unpacks the input item, drops shell and out-of-grid coordinates, works out
// which neighbours are interior and pushes a command into the queue.
// ----------------------------------------------------------------------------
module vbfe_front #(
	parameter int GRID_SIZE = vbfe_pkg::GRID_SIZE_DEF
) (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: vox_x[5:0], vox_y[11:6], vox_z[17:12], occupied[18], zero pad
	input  logic [vbfe_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: mode[0]
	input  logic [0:0]                     s_tuser,
	input  vbfe_pkg::queue_stat_t          q_stat,
	input  logic                           clearing,
	output logic                           q_push,
	output vbfe_pkg::cmd_t                 q_cmd
);

	localparam logic [8:0] TOP    = 9'(GRID_SIZE - 1);
	localparam logic [8:0] TOP_M1 = 9'(GRID_SIZE - 2);

	logic [8:0] x9, y9, z9;
	logic       interior;

	// field unpacking
	assign x9 = 9'(s_tdata[5:0]);
	assign y9 = 9'(s_tdata[11:6]);
	assign z9 = 9'(s_tdata[17:12]);

	assign interior = (x9 != 9'd0) && (x9 < TOP) &&
	                  (y9 != 9'd0) && (y9 < TOP) &&
	                  (z9 != 9'd0) && (z9 < TOP);

	// command build
	always_comb begin
		q_cmd       = '0;
		q_cmd.mode  = s_tuser[0];
		q_cmd.x     = s_tdata[5:0];
		q_cmd.y     = s_tdata[11:6];
		q_cmd.z     = s_tdata[17:12];
		q_cmd.occ   = s_tdata[18];
		q_cmd.nb_in[vbfe_pkg::DIR_ZN] = (z9 >= 9'd2);
		q_cmd.nb_in[vbfe_pkg::DIR_ZP] = (z9 < TOP_M1);
		q_cmd.nb_in[vbfe_pkg::DIR_XN] = (x9 >= 9'd2);
		q_cmd.nb_in[vbfe_pkg::DIR_XP] = (x9 < TOP_M1);
		q_cmd.nb_in[vbfe_pkg::DIR_YN] = (y9 >= 9'd2);
		q_cmd.nb_in[vbfe_pkg::DIR_YP] = (y9 < TOP_M1);
	end

	// accept when not full or clearing; shell items are taken and dropped
	assign s_tready = !q_stat.full && !clearing;
	assign q_push   = s_tvalid && s_tready && interior;

endmodule

>>> sv/vbfe_queue.sv
// ----------------------------------------------------------------------------
// vbfe_queue: small command queue
// Decouples classification from the memory sequencer.
// ----------------------------------------------------------------------------
module vbfe_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vbfe_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output vbfe_pkg::cmd_t        head,
	output vbfe_pkg::queue_stat_t stat
);

	localparam int DEPTH = vbfe_pkg::QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	vbfe_pkg::cmd_t  entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push, do_pop;

	assign stat.full  = (count_q == CNTW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

>>> sv/vbfe_back.sv
// ----------------------------------------------------------------------------
// vbfe_back: occupancy memory and face sequencer
// Holds the grid as one x-row per memory word in a single-port memory.
// Writes are read-modify-write of a row; queries read five rows in turn and
// then emit one face record per exposed neighbour through an output register.
// ----------------------------------------------------------------------------
module vbfe_back #(
	parameter int GRID_SIZE = vbfe_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vbfe_pkg::queue_stat_t          q_stat,
	input  vbfe_pkg::cmd_t                 q_head,
	output logic                           q_pop,
	output logic                           clearing,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vbfe_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	localparam int CW    = $clog2(GRID_SIZE);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;

	// row read order during a query
	localparam logic [2:0] ROW_C    = 3'd0;
	localparam logic [2:0] ROW_ZN   = 3'd1;
	localparam logic [2:0] ROW_ZP   = 3'd2;
	localparam logic [2:0] ROW_YN   = 3'd3;
	localparam logic [2:0] ROW_YP   = 3'd4;
	localparam logic [2:0] ROW_DONE = 3'd5;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_WR_RD = 6'b000100,
		ST_WR_WB = 6'b001000,
		ST_Q_RD  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 clr_addr_q;
	logic [2:0]                    cnt_q;
	vbfe_pkg::cmd_t                cmd_q;
	logic                          occ_c_q;
	logic [vbfe_pkg::NUM_DIR-1:0]  solid_q, solid_now, pending_q, pend_rest;
	logic [vbfe_pkg::DIR_W-1:0]    emit_dir;
	logic                          m_tvalid_q, m_tlast_q, out_free;
	logic [vbfe_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic [GRID_SIZE-1:0] mem [DEPTH];
	logic [GRID_SIZE-1:0] rd_data_s1, row_mod, mem_wdata;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we;

	logic [CW-1:0] xi, xm, xp, yi, ym, yp, zi, zm, zp;

	// neighbour coordinates of the held command
	assign xi = CW'(cmd_q.x);
	assign yi = CW'(cmd_q.y);
	assign zi = CW'(cmd_q.z);
	assign xm = xi - CW'(1);
	assign xp = xi + CW'(1);
	assign ym = yi - CW'(1);
	assign yp = yi + CW'(1);
	assign zm = zi - CW'(1);
	assign zp = zi + CW'(1);

	// memory address and write data
	always_comb begin
		mem_addr = {zi, yi};
		case (state_q)
			ST_CLEAR: mem_addr = clr_addr_q;
			ST_Q_RD: begin
				case (cnt_q)
					ROW_ZN:  mem_addr = {zm, yi};
					ROW_ZP:  mem_addr = {zp, yi};
					ROW_YN:  mem_addr = {zi, ym};
					ROW_YP:  mem_addr = {zi, yp};
					default: mem_addr = {zi, yi};
				endcase
			end
			default: mem_addr = {zi, yi};
		endcase
	end

	always_comb begin
		row_mod     = rd_data_s1;
		row_mod[xi] = cmd_q.occ;
	end

	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WR_WB);
	assign mem_wdata = (state_q == ST_CLEAR) ? '1 : row_mod;

	// single-port row memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_addr];
	end

	// last neighbour row completes the solid mask
	always_comb begin
		solid_now                   = solid_q;
		solid_now[vbfe_pkg::DIR_YP] = rd_data_s1[xi];
	end

	// next record to emit
	assign emit_dir  = vbfe_pkg::first_dir(pending_q);
	assign pend_rest = pending_q & ~(vbfe_pkg::NUM_DIR'(1) << emit_dir);
	assign out_free  = !m_tvalid_q || m_tready;

	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty;
	assign clearing = (state_q == ST_CLEAR);

	// held command and gathered occupancy
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == ST_Q_RD) begin
			case (cnt_q)
				ROW_ZN: begin
					occ_c_q                   <= rd_data_s1[xi];
					solid_q[vbfe_pkg::DIR_XN] <= rd_data_s1[xm];
					solid_q[vbfe_pkg::DIR_XP] <= rd_data_s1[xp];
				end
				ROW_ZP:   solid_q[vbfe_pkg::DIR_ZN] <= rd_data_s1[xi];
				ROW_YN:   solid_q[vbfe_pkg::DIR_ZP] <= rd_data_s1[xi];
				ROW_YP:   solid_q[vbfe_pkg::DIR_YN] <= rd_data_s1[xi];
				ROW_DONE: solid_q[vbfe_pkg::DIR_YP] <= rd_data_s1[xi];
				default: ;
			endcase
		end
		if ((state_q == ST_EMIT) && (pending_q != '0) && out_free) begin
			m_tdata_q <= {3'b000, emit_dir, cmd_q.z, cmd_q.y, cmd_q.x};
			m_tlast_q <= (pend_rest == '0);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			cnt_q      <= ROW_C;
			pending_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output register: load a record or empty on acceptance
			if ((state_q == ST_EMIT) && (pending_q != '0) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						cnt_q   <= ROW_C;
						state_q <= (q_head.mode == vbfe_pkg::MODE_QUERY) ? ST_Q_RD : ST_WR_RD;
					end
				end
				ST_WR_RD: state_q <= ST_WR_WB;
				ST_WR_WB: state_q <= ST_IDLE;
				ST_Q_RD: begin
					if (cnt_q == ROW_DONE) begin
						pending_q <= occ_c_q ? ~(solid_now & cmd_q.nb_in) : '0;
						state_q   <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_EMIT: begin
					if (pending_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pending_q <= pend_rest;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> sv/voxel_boundary_face_extract.sv
// ----------------------------------------------------------------------------
// voxel_boundary_face_extract: exposed face extraction on a voxel grid
// Keeps a one-bit occupancy grid and lists the exposed faces of a voxel.
//
//   channel  | dir | fields
//   ---------+-----+-----------------------------------------------------
//   s_axis   | in  | tuser: mode; tdata: vox_x, vox_y, vox_z, occupied
//   m_axis   | out | tdata: face_x, face_y, face_z, direction; tlast: last
//
// A write takes three back-end steps: queue pop, row read, row write.
// A query makes five row reads through the single-port memory, then emits one
// record per exposed face (0 to 6), one per cycle while m_tready is high.
// After reset a clearing pass sets every row to occupied, one row a cycle,
// over all 2^(2*clog2(GRID_SIZE)) rows, 4096 at the default size; s_tready is low.
// A two-item queue lets the input side run ahead while m_tready is low.
// ----------------------------------------------------------------------------
module voxel_boundary_face_extract #(
	parameter int GRID_SIZE = vbfe_pkg::GRID_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: vox_x[5:0], vox_y[11:6], vox_z[17:12], occupied[18], zero pad
	input  logic [vbfe_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: mode[0]
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: face_x[5:0], face_y[11:6], face_z[17:12], direction[20:18], pad
	output logic [vbfe_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	vbfe_pkg::queue_stat_t q_stat;
	vbfe_pkg::cmd_t        push_cmd, head_cmd;
	logic                  q_push, q_pop, clearing;

	vbfe_front #(.GRID_SIZE(GRID_SIZE)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.clearing (clearing),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	vbfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.stat     (q_stat)
	);

	vbfe_back #(.GRID_SIZE(GRID_SIZE)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_head   (head_cmd),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> sv/vbfe_check.sv
// ----------------------------------------------------------------------------
// vbfe_check: port-level checks for the face extractor
// Watches the result channel and flags records the block cannot produce.
// ----------------------------------------------------------------------------
module vbfe_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vbfe_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	// a stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// direction code in range and padding clear
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20:18] <= 3'd5) && (m_tdata[23:21] == 3'd0))
		else $error("bad direction or padding");

	// y+ is always the final face of a query
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:18] == 3'd5) |-> m_tlast)
		else $error("y+ face not marked last");

	// only interior voxels own faces
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] != 6'd0) && (m_tdata[11:6] != 6'd0) &&
		             (m_tdata[17:12] != 6'd0))
		else $error("face on a shell voxel");

endmodule

bind voxel_boundary_face_extract vbfe_check u_vbfe_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
